// ===== design/assert_macros.svh =====
// Assertion macros for the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/seei_pkg.sv =====
package seei_pkg;

    // Opcodes of the command word.
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_ABSOLUTE = 2'd1;
    localparam logic [1:0] OP_RELATIVE = 2'd2;
    localparam logic [1:0] OP_TARGET   = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_REVERSE_START    = 3'd0;
    localparam logic [2:0] CFG_BACK_AND_FORTH   = 3'd1;
    localparam logic [2:0] CFG_ENDLESS          = 3'd2;
    localparam logic [2:0] CFG_USE_REPEAT_COUNT = 3'd3;
    localparam logic [2:0] CFG_REPEAT_COUNT     = 3'd4;

    // Frame count used when a command gives zero frames.
    localparam logic [15:0] DEFAULT_FRAMES = 16'd32;

    // Angle limits in hundredths of a degree.
    localparam logic signed [17:0] ANGLE_MAX_W = 18'sd18000;
    localparam logic signed [17:0] ANGLE_MIN_W = -18'sd18000;
    localparam logic signed [15:0] ANGLE_MAX   = 16'sd18000;
    localparam logic signed [15:0] ANGLE_MIN   = -16'sd18000;

    // Restoring divider: one quotient bit per cycle.
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Command word.
    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] first_angle;
        logic signed [15:0] second_angle;
        logic [15:0]        frame_total;
    } seei_in_t;

    // Result word.
    typedef struct packed {
        logic signed [15:0] angle;
        logic               active;
    } seei_out_t;

    // Clamp a widened angle to the legal range.
    function automatic logic signed [15:0] sat_angle(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > ANGLE_MAX_W)
        begin
            r = ANGLE_MAX;
        end
        else if (v < ANGLE_MIN_W)
        begin
            r = ANGLE_MIN;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== design/seei_div.sv =====
module seei_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);

    logic [15:0]                    rem_reg, rem_next;
    logic [15:0]                    low_reg, low_next;
    logic [seei_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [16:0]                    trial;
    logic [16:0]                    diff;
    logic                           fits;

    // One restoring step: bring down the next dividend bit and try the subtraction.
    // The upper half of the dividend is known to be below the divisor, so the
    // quotient fits in sixteen bits and sixteen steps suffice.
    assign trial = {rem_reg, low_reg[15]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend[31:16];
            low_next  = dividend[15:0];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[15:0] : trial[15:0];
            low_next = {low_reg[14:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == seei_pkg::DIV_CNT_W'(seei_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            low_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            low_reg  <= low_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Quotient bits have shifted fully into the low word when done pulses.
    assign done     = done_reg;
    assign quotient = low_reg;

endmodule

// ===== design/servo_angle_easing_interpolator.sv =====
// Channel | Direction | Handshake         | Word
// cmd     | in        | cmd_valid/stall   | seei_in_t: opcode, angles, frame_total
// res     | out       | res_valid/stall   | seei_out_t: angle, active
// cfg     | in        | cfg_valid/ready   | cfg_index, cfg_data
//
// A move command or an idle or final-frame tick goes straight to the output
// step; the block stalls from acceptance until it leaves that step. An
// interpolated frame also passes the multiply, divider start, divider wait
// and finishing steps, the wait set by the 16-step restoring divider's done flag.
// The result register lets a new word be accepted while the last result waits.
// A stalled result holds the block in its output step until the result can be
// loaded. Reset is asynchronous and active low; configuration is always ready.
module servo_angle_easing_interpolator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  seei_pkg::seei_in_t  cmd,
    output logic                res_valid,
    input  logic                res_stall,
    output seei_pkg::seei_out_t res,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_DSTART = 3'd2;
    localparam logic [2:0] S_DWAIT  = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]          state_reg, state_next;

    // Configuration registers.
    logic                rev_reg, bnf_reg, endless_reg, use_rep_reg;
    logic [7:0]          rep_reg;

    // Motion state.
    logic signed [15:0]  start_reg, start_next;
    logic signed [15:0]  stop_reg, stop_next;
    logic signed [15:0]  cur_reg, cur_next;
    logic [15:0]         index_reg, index_next;
    logic [15:0]         count_reg, count_next;
    logic                back_reg, back_next;
    logic [8:0]          runs_reg, runs_next;

    // Working registers of the interpolation.
    logic [15:0]         mag_reg, mag_next;
    logic [15:0]         num_reg, num_next;
    logic [15:0]         den_reg, den_next;
    logic                neg_reg, neg_next;
    logic [31:0]         prod_reg, prod_next;
    logic                act_reg, act_next;

    // Result register.
    logic                res_valid_reg, res_valid_next;
    seei_pkg::seei_out_t res_reg, res_next;

    logic                accept;
    logic signed [16:0]  rel_sum;
    logic signed [15:0]  load_start, load_stop;
    logic [15:0]         load_frames;
    logic [8:0]          load_runs;
    logic [8:0]          single_runs;
    logic [16:0]         idx_raw;
    logic                wrap;
    logic                back_tick;
    logic [15:0]         idx_tick;
    logic                last_frame;
    logic signed [16:0]  delta;
    logic [16:0]         delta_abs;
    logic                div_start;
    logic                div_done;
    logic [15:0]         quotient;
    logic signed [17:0]  d_signed;
    logic signed [17:0]  interp;

    assign cmd_stall = state_reg != S_IDLE;
    assign accept    = cmd_valid && !cmd_stall;
    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rev_reg     <= 1'b0;
            bnf_reg     <= 1'b0;
            endless_reg <= 1'b0;
            use_rep_reg <= 1'b0;
            rep_reg     <= 8'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                seei_pkg::CFG_REVERSE_START:    rev_reg     <= cfg_data[0];
                seei_pkg::CFG_BACK_AND_FORTH:   bnf_reg     <= cfg_data[0];
                seei_pkg::CFG_ENDLESS:          endless_reg <= cfg_data[0];
                seei_pkg::CFG_USE_REPEAT_COUNT: use_rep_reg <= cfg_data[0];
                seei_pkg::CFG_REPEAT_COUNT:     rep_reg     <= cfg_data;
                default:                        ;
            endcase
        end
    end

    // Values loaded by a move command.
    assign rel_sum     = {cur_reg[15], cur_reg} + {cmd.first_angle[15], cmd.first_angle};
    assign load_start  = (cmd.opcode == seei_pkg::OP_ABSOLUTE)
                         ? seei_pkg::sat_angle(18'(cmd.first_angle)) : cur_reg;
    assign load_frames = (cmd.frame_total == 16'd0) ? seei_pkg::DEFAULT_FRAMES
                                                    : cmd.frame_total;
    assign single_runs = use_rep_reg ? {1'b0, rep_reg} : 9'd1;
    assign load_runs   = endless_reg ? 9'd1
                         : (bnf_reg ? {single_runs[7:0], 1'b0} : single_runs);

    always_comb
    begin
        case (cmd.opcode)
            seei_pkg::OP_ABSOLUTE: load_stop = seei_pkg::sat_angle(18'(cmd.second_angle));
            seei_pkg::OP_RELATIVE: load_stop = seei_pkg::sat_angle(18'(rel_sum));
            default:               load_stop = seei_pkg::sat_angle(18'(cmd.first_angle));
        endcase
    end

    // Frame advance of a tick, with wrap at the run end.
    assign idx_raw    = {1'b0, index_reg} + 17'd1;
    assign wrap       = idx_raw > {1'b0, count_reg};
    assign back_tick  = back_reg ^ (wrap && bnf_reg);
    assign idx_tick   = !wrap ? idx_raw[15:0]
                        : ((bnf_reg && (count_reg >= 16'd2)) ? 16'd2 : 16'd1);
    assign last_frame = idx_tick == count_reg;

    // Span between the end points, as sign and magnitude.
    assign delta     = {stop_reg[15], stop_reg} - {start_reg[15], start_reg};
    assign delta_abs = delta[16] ? 17'(-delta) : 17'(delta);

    // Signed step and the interpolated angle once the quotient is in.
    assign d_signed = neg_reg ? -$signed({2'b00, quotient}) : $signed({2'b00, quotient});
    assign interp   = back_reg ? (18'(stop_reg) - d_signed) : (18'(start_reg) + d_signed);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        start_next     = start_reg;
        stop_next      = stop_reg;
        cur_next       = cur_reg;
        index_next     = index_reg;
        count_next     = count_reg;
        back_next      = back_reg;
        runs_next      = runs_reg;
        mag_next       = mag_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        prod_next      = prod_reg;
        act_next       = act_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && res_stall;
        div_start      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_OUT;
                    if (cmd.opcode == seei_pkg::OP_TICK)
                    begin
                        if (runs_reg == 9'd0)
                        begin
                            act_next = 1'b0;
                        end
                        else
                        begin
                            act_next   = 1'b1;
                            index_next = idx_tick;
                            back_next  = back_tick;
                            if (last_frame)
                            begin
                                cur_next = back_tick ? start_reg : stop_reg;
                                if (!endless_reg)
                                begin
                                    runs_next = runs_reg - 9'd1;
                                end
                            end
                            else
                            begin
                                mag_next   = delta_abs[15:0];
                                neg_next   = delta[16];
                                num_next   = idx_tick - 16'd1;
                                den_next   = count_reg - 16'd1;
                                state_next = S_MUL;
                            end
                        end
                    end
                    else
                    begin
                        start_next = load_start;
                        stop_next  = load_stop;
                        cur_next   = load_start;
                        index_next = 16'd0;
                        count_next = load_frames;
                        back_next  = rev_reg;
                        runs_next  = load_runs;
                        act_next   = load_runs != 9'd0;
                    end
                end
            end
            S_MUL:
            begin
                // Numerator with half the divisor added for rounding to nearest.
                prod_next  = (32'(mag_reg) * 32'(num_reg)) + 32'(den_reg[15:1]);
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                div_start  = 1'b1;
                state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cur_next   = seei_pkg::sat_angle(interp);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    res_next.angle  = cur_reg;
                    res_next.active = act_reg;
                    res_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= '0;
            stop_reg      <= '0;
            cur_reg       <= '0;
            index_reg     <= '0;
            count_reg     <= seei_pkg::DEFAULT_FRAMES;
            back_reg      <= 1'b0;
            runs_reg      <= '0;
            act_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            stop_reg      <= stop_next;
            cur_reg       <= cur_next;
            index_reg     <= index_next;
            count_reg     <= count_next;
            back_reg      <= back_next;
            runs_reg      <= runs_next;
            act_reg       <= act_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Working and result payload registers need no reset.
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    // Serial divider for the step fraction.
    seei_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== design/seei_checker.sv =====
`include "assert_macros.svh"

module seei_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_stall,
    input logic                res_valid,
    input logic                res_stall,
    input seei_pkg::seei_out_t res
);

    // A stalled result word must stay put.
    `ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "result word changed while stalled")

    // Every shown angle lies within the legal range.
    `ASSERT_SAME(a_res_range, res_valid, ($signed(res.angle) <= seei_pkg::ANGLE_MAX) && ($signed(res.angle) >= seei_pkg::ANGLE_MIN), "result angle out of range")

    // Once a command word is taken the block works on it before taking another.
    `ASSERT_NEXT(a_busy_after_accept, cmd_valid && !cmd_stall, cmd_stall, "command accepted while still working")

    // The block only becomes ready again with the finished result on show.
    `ASSERT_SAME(a_ready_with_result, $fell(cmd_stall), res_valid, "ready again without a result")

endmodule

bind servo_angle_easing_interpolator seei_checker u_seei_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
